[design/ll1ep_pkg.sv]
`timescale 1ns / 1ps
// ll1ep_pkg: symbol codes, status codes, cell control word and the parse table
// used by the expression parser cells, top level and checker; no dependencies

package ll1ep_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;

	typedef logic [3:0] sym_t;
	typedef logic [1:0] status_t;

	localparam sym_t SYM_END  = 4'd0;
	localparam sym_t SYM_E    = 4'd1;
	localparam sym_t SYM_Q    = 4'd2;
	localparam sym_t SYM_T    = 4'd3;
	localparam sym_t SYM_R    = 4'd4;
	localparam sym_t SYM_F    = 4'd5;
	localparam sym_t SYM_ID   = 4'd6;
	localparam sym_t SYM_PLUS = 4'd7;
	localparam sym_t SYM_STAR = 4'd8;
	localparam sym_t SYM_LP   = 4'd9;
	localparam sym_t SYM_RP   = 4'd10;
	localparam sym_t SYM_NONE = 4'd15;

	localparam status_t ST_CONSUMED = 2'd0;
	localparam status_t ST_ACCEPTED = 2'd1;
	localparam status_t ST_REJECTED = 2'd2;
	localparam status_t ST_IGNORED  = 2'd3;

	localparam logic [7:0] CH_END  = 8'h24;
	localparam logic [7:0] CH_ID   = 8'h69;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_LP   = 8'h28;
	localparam logic [7:0] CH_RP   = 8'h29;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_POP,
		SH_PUSH1,
		SH_PUSH2
	} shift_t;

	typedef struct packed {
		logic   load;
		sym_t   load_sym;
		shift_t shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] len;
		sym_t       b0;
		sym_t       b1;
		sym_t       b2;
	} rule_t;

	typedef enum logic {
		S_IDLE,
		S_WORK
	} fsm_t;

	function automatic sym_t token_code(input logic [7:0] ch);
		sym_t s;
		case (ch)
			CH_END:  s = SYM_END;
			CH_ID:   s = SYM_ID;
			CH_PLUS: s = SYM_PLUS;
			CH_STAR: s = SYM_STAR;
			CH_LP:   s = SYM_LP;
			CH_RP:   s = SYM_RP;
			default: s = SYM_NONE;
		endcase
		return s;
	endfunction

	// body in push order: b0 deepest, last one ends on top
	function automatic rule_t table_rule(input sym_t nt, input sym_t t);
		rule_t r;
		r = '{ok: 1'b0, len: 2'd0, b0: SYM_END, b1: SYM_END, b2: SYM_END};
		case (nt)
			SYM_E: begin
				if (t == SYM_ID || t == SYM_LP)
					r = '{ok: 1'b1, len: 2'd2, b0: SYM_Q, b1: SYM_T, b2: SYM_END};
			end
			SYM_Q: begin
				if (t == SYM_PLUS)
					r = '{ok: 1'b1, len: 2'd3, b0: SYM_Q, b1: SYM_T, b2: SYM_PLUS};
				else if (t == SYM_RP || t == SYM_END)
					r.ok = 1'b1;
			end
			SYM_T: begin
				if (t == SYM_ID || t == SYM_LP)
					r = '{ok: 1'b1, len: 2'd2, b0: SYM_R, b1: SYM_F, b2: SYM_END};
			end
			SYM_R: begin
				if (t == SYM_STAR)
					r = '{ok: 1'b1, len: 2'd3, b0: SYM_R, b1: SYM_F, b2: SYM_STAR};
				else if (t == SYM_PLUS || t == SYM_RP || t == SYM_END)
					r.ok = 1'b1;
			end
			SYM_F: begin
				if (t == SYM_ID)
					r = '{ok: 1'b1, len: 2'd1, b0: SYM_ID, b1: SYM_END, b2: SYM_END};
				else if (t == SYM_LP)
					r = '{ok: 1'b1, len: 2'd3, b0: SYM_RP, b1: SYM_E, b2: SYM_LP};
			end
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[design/ll1ep_cell.sv]
`timescale 1ns / 1ps
// ll1ep_cell: one entry of the shifting symbol stack
// depends on ll1ep_pkg

module ll1ep_cell #(
	parameter ll1ep_pkg::sym_t INIT_SYM = ll1ep_pkg::SYM_END
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ll1ep_pkg::cell_ctrl_t  ctrl,
	input  ll1ep_pkg::sym_t        from_below,
	input  ll1ep_pkg::sym_t        from_above1,
	input  ll1ep_pkg::sym_t        from_above2,
	output ll1ep_pkg::sym_t        sym
);
	import ll1ep_pkg::*;

	sym_t sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= INIT_SYM;
		end else if (ctrl.load) begin
			sym_q <= ctrl.load_sym;
		end else begin
			case (ctrl.shift)
				SH_POP:   sym_q <= from_below;
				SH_PUSH1: sym_q <= from_above1;
				SH_PUSH2: sym_q <= from_above2;
				default:  sym_q <= sym_q;
			endcase
		end
	end

	assign sym = sym_q;

endmodule

[design/ll1_expression_parser_unit.sv]
`timescale 1ns / 1ps
// ll1_expression_parser_unit: ll(1) predictive parser for the expression grammar
// depends on ll1ep_pkg and ll1ep_cell

// One token word goes in, one result word comes out. The symbol stack is a row of
// STACK_DEPTH cells with the top in cell 0; a rule or a match shifts the whole row
// by up to two places at once. A token is first taken in; then one grammar rule is
// applied per step, at most three, and a last step matches, rejects or (while
// discarding up to the end marker) ignores it; a new token is taken once the previous
// one is done. A result that is not yet taken stalls the finish of the next token.
module ll1_expression_parser_unit #(
	parameter int unsigned STACK_DEPTH = ll1ep_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                token_valid,
	output logic                token_ready,
	input  logic [7:0]          token,
	output logic                result_valid,
	input  logic                result_ready,
	output ll1ep_pkg::status_t  status,
	output logic [1:0]          expansions
);
	import ll1ep_pkg::*;

	localparam int unsigned SPW = $clog2(STACK_DEPTH);

	fsm_t           state_q, state_d;
	sym_t           tok_q;
	logic [1:0]     count_q;
	logic [SPW-1:0] sp_q;
	logic           discarding_q;
	logic           out_valid_q;
	status_t        status_q;
	logic [1:0]     exp_q;

	sym_t           cells [STACK_DEPTH];
	cell_ctrl_t     ctrl_top [3];
	shift_t         shift_all;

	sym_t           top;
	logic           nonterm;
	rule_t          rule;
	logic [SPW+1:0] sp_sum;
	logic           overflow;
	logic           can_out;

	logic           finish, expand, restart, pop, set_disc, clr_disc;
	status_t        fin_status;

	assign top      = cells[0];
	assign nonterm  = top inside {[SYM_E:SYM_F]};
	assign rule     = table_rule(top, tok_q);
	assign sp_sum   = {2'b00, sp_q} + {{SPW{1'b0}}, rule.len};
	assign overflow = sp_sum > (SPW+2)'(STACK_DEPTH);
	assign can_out  = !out_valid_q || result_ready;

	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		expand     = 1'b0;
		restart    = 1'b0;
		pop        = 1'b0;
		set_disc   = 1'b0;
		clr_disc   = 1'b0;
		fin_status = ST_REJECTED;
		case (state_q)
			S_IDLE: begin
				if (token_valid)
					state_d = S_WORK;
			end
			S_WORK: begin
				if (discarding_q) begin
					finish     = 1'b1;
					fin_status = ST_IGNORED;
				end else if (!nonterm) begin
					finish = 1'b1;
					if (top == tok_q)
						fin_status = (tok_q == SYM_END) ? ST_ACCEPTED : ST_CONSUMED;
				end else if (count_q == 2'd3 || !rule.ok || overflow) begin
					finish = 1'b1;
				end else begin
					expand = 1'b1;
				end
				if (finish && can_out) begin
					state_d = S_IDLE;
					case (fin_status)
						ST_IGNORED: begin
							if (tok_q == SYM_END) begin
								clr_disc = 1'b1;
								restart  = 1'b1;
							end
						end
						ST_ACCEPTED: restart = 1'b1;
						ST_CONSUMED: pop = 1'b1;
						default: begin
							if (tok_q == SYM_END)
								restart = 1'b1;
							else
								set_disc = 1'b1;
						end
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// shift and top loads for the cell row
	always_comb begin
		shift_all = SH_HOLD;
		for (int j = 0; j < 3; j++)
			ctrl_top[j] = '{load: 1'b0, load_sym: SYM_END, shift: SH_HOLD};
		if (pop) begin
			shift_all = SH_POP;
		end else if (expand) begin
			case (rule.len)
				2'd0:    shift_all = SH_POP;
				2'd2:    shift_all = SH_PUSH1;
				2'd3:    shift_all = SH_PUSH2;
				default: shift_all = SH_HOLD;
			endcase
		end
		for (int j = 0; j < 3; j++)
			ctrl_top[j].shift = shift_all;
		if (restart) begin
			ctrl_top[0].load     = 1'b1;
			ctrl_top[0].load_sym = SYM_E;
			ctrl_top[1].load     = 1'b1;
			ctrl_top[1].load_sym = SYM_END;
		end else if (expand) begin
			case (rule.len)
				2'd1: begin
					ctrl_top[0] = '{load: 1'b1, load_sym: rule.b0, shift: shift_all};
				end
				2'd2: begin
					ctrl_top[0] = '{load: 1'b1, load_sym: rule.b1, shift: shift_all};
					ctrl_top[1] = '{load: 1'b1, load_sym: rule.b0, shift: shift_all};
				end
				2'd3: begin
					ctrl_top[0] = '{load: 1'b1, load_sym: rule.b2, shift: shift_all};
					ctrl_top[1] = '{load: 1'b1, load_sym: rule.b1, shift: shift_all};
					ctrl_top[2] = '{load: 1'b1, load_sym: rule.b0, shift: shift_all};
				end
				default: ctrl_top[0].load = 1'b0;
			endcase
		end
	end

	for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
		cell_ctrl_t ctrl_j;
		sym_t       below_j, above1_j, above2_j;

		if (j < 3) begin : g_top
			assign ctrl_j = ctrl_top[j];
		end else begin : g_deep
			assign ctrl_j = '{load: 1'b0, load_sym: SYM_END, shift: shift_all};
		end
		if (j + 1 < STACK_DEPTH) begin : g_below
			assign below_j = cells[j+1];
		end else begin : g_nobelow
			assign below_j = SYM_END;
		end
		if (j >= 1) begin : g_a1
			assign above1_j = cells[j-1];
		end else begin : g_noa1
			assign above1_j = SYM_END;
		end
		if (j >= 2) begin : g_a2
			assign above2_j = cells[j-2];
		end else begin : g_noa2
			assign above2_j = SYM_END;
		end

		ll1ep_cell #(
			.INIT_SYM((j == 0) ? SYM_E : SYM_END)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl_j),
			.from_below (below_j),
			.from_above1(above1_j),
			.from_above2(above2_j),
			.sym        (cells[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= 2'd0;
			sp_q         <= SPW'(1);
			discarding_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && token_valid)
				count_q <= 2'd0;
			else if (expand)
				count_q <= count_q + 2'd1;
			if (restart)
				sp_q <= SPW'(1);
			else if (pop)
				sp_q <= sp_q - SPW'(1);
			else if (expand)
				sp_q <= sp_sum[SPW-1:0] - SPW'(1);
			if (set_disc)
				discarding_q <= 1'b1;
			else if (clr_disc)
				discarding_q <= 1'b0;
			if (finish && can_out)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && token_valid)
			tok_q <= token_code(token);
		if (finish && can_out) begin
			status_q <= fin_status;
			exp_q    <= discarding_q ? 2'd0 : count_q;
		end
	end

	assign token_ready  = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign expansions   = exp_q;

endmodule

[design/ll1ep_checker.sv]
`timescale 1ns / 1ps
// ll1ep_checker: port-level assertions for the expression parser
// depends on ll1ep_pkg; bound to ll1_expression_parser_unit

module ll1ep_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                token_valid,
	input logic                token_ready,
	input logic [7:0]          token,
	input logic                result_valid,
	input logic                result_ready,
	input ll1ep_pkg::status_t  status,
	input logic [1:0]          expansions
);
	import ll1ep_pkg::*;

	// ignored words never report rule expansions
	a_ignored_no_exp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_IGNORED |-> expansions == 2'd0)
		else $error("ignored word reports expansions");

	// one word in flight: busy right after a word is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_ready |=> !token_ready)
		else $error("ready right after taking a word");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(status) && $stable(expansions))
		else $error("stalled result changed");

	// a waiting token word holds
	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token))
		else $error("waiting token word changed");

endmodule

bind ll1_expression_parser_unit ll1ep_checker u_ll1ep_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_ready (token_ready),
	.token       (token),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.status      (status),
	.expansions  (expansions)
);

[sim/parse_check_pkg.sv]
`timescale 1ns / 1ps
// parse_check_pkg: scoreboard for the expression parser, holding its own copy of the
// symbol stack and the queue of verdicts still due; depends on ll1ep_pkg

package parse_check_pkg;

	import ll1ep_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [1:0] expansions;
	} verdict_t;

	class parse_scoreboard;

		sym_t        stk [STACK_DEPTH_DEF];
		int unsigned sp;
		bit          discarding;
		verdict_t    due [$];

		int unsigned tokens;
		int unsigned accepts;
		int unsigned rejects;
		int unsigned ignored;
		int unsigned overflows;
		int unsigned checked;
		int unsigned mismatches;

		function new();
			restart();
			discarding = 1'b0;
		endfunction

		function void restart();
			foreach (stk[k])
				stk[k] = SYM_END;
			stk[1] = SYM_E;
			sp = 1;
		endfunction

		function sym_t symbol_of(input logic [7:0] ch);
			case (ch)
				CH_END:  return SYM_END;
				CH_ID:   return SYM_ID;
				CH_PLUS: return SYM_PLUS;
				CH_STAR: return SYM_STAR;
				CH_LP:   return SYM_LP;
				CH_RP:   return SYM_RP;
				default: return SYM_NONE;
			endcase
		endfunction

		// right side from the deepest entry up; -1 when no table entry
		function int production(input sym_t nt, input sym_t t, output sym_t body [3]);
			body = '{SYM_END, SYM_END, SYM_END};
			case (nt)
				SYM_E: begin
					if (t == SYM_ID || t == SYM_LP) begin
						body[0] = SYM_Q;
						body[1] = SYM_T;
						return 2;
					end
				end
				SYM_T: begin
					if (t == SYM_ID || t == SYM_LP) begin
						body[0] = SYM_R;
						body[1] = SYM_F;
						return 2;
					end
				end
				SYM_Q: begin
					if (t == SYM_PLUS) begin
						body = '{SYM_Q, SYM_T, SYM_PLUS};
						return 3;
					end
					if (t == SYM_RP || t == SYM_END)
						return 0;
				end
				SYM_R: begin
					if (t == SYM_STAR) begin
						body = '{SYM_R, SYM_F, SYM_STAR};
						return 3;
					end
					if (t == SYM_PLUS || t == SYM_RP || t == SYM_END)
						return 0;
				end
				SYM_F: begin
					if (t == SYM_ID) begin
						body[0] = SYM_ID;
						return 1;
					end
					if (t == SYM_LP) begin
						body = '{SYM_RP, SYM_E, SYM_LP};
						return 3;
					end
				end
				default: ;
			endcase
			return -1;
		endfunction

		function void note_token(input logic [7:0] ch);
			sym_t        t;
			sym_t        top;
			sym_t        body [3];
			int          n;
			int unsigned count;
			status_t     st;
			bit          settled;
			t = symbol_of(ch);
			count = 0;
			st = ST_REJECTED;
			settled = 1'b0;
			tokens++;
			if (discarding) begin
				if (t == SYM_END) begin
					discarding = 1'b0;
					restart();
				end
				ignored++;
				due.push_back('{ST_IGNORED, 2'd0});
				return;
			end
			while (!settled) begin
				top = stk[sp % STACK_DEPTH_DEF];
				if (!(top >= SYM_E && top <= SYM_F)) begin
					if (top == t) begin
						if (t == SYM_END) begin
							st = ST_ACCEPTED;
						end else begin
							st = ST_CONSUMED;
							if (sp > 0)
								sp--;
						end
					end
					settled = 1'b1;
				end else if (count >= 3) begin
					settled = 1'b1;
				end else begin
					n = production(top, t, body);
					if (n < 0) begin
						settled = 1'b1;
					end else if (sp + n > STACK_DEPTH_DEF) begin
						overflows++;
						settled = 1'b1;
					end else begin
						sp = sp - 1;
						for (int k = 0; k < n; k++) begin
							sp++;
							stk[sp % STACK_DEPTH_DEF] = body[k];
						end
						count++;
					end
				end
			end
			if (st == ST_ACCEPTED) begin
				accepts++;
				restart();
			end else if (st == ST_REJECTED) begin
				rejects++;
				if (t == SYM_END)
					restart();
				else
					discarding = 1'b1;
			end
			due.push_back('{st, count[1:0]});
		endfunction

		function void fault(input string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_verdict(input status_t status, input logic [1:0] expansions);
			verdict_t want;
			if (due.size() == 0) begin
				fault($sformatf("result word with nothing due: status %0d expansions %0d",
					status, expansions));
				return;
			end
			want = due.pop_front();
			checked++;
			if (status !== want.status || expansions !== want.expansions)
				fault($sformatf("word %0d: status exp %0d got %0d, expansions exp %0d got %0d",
					checked, want.status, status, want.expansions, expansions));
		endfunction

	endclass

endpackage

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: drives token words into ll1_expression_parser_unit and checks every result
// word against parse_check_pkg; depends on ll1ep_pkg and parse_check_pkg

module testbench;

	import ll1ep_pkg::*;
	import parse_check_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned TOKEN_GOAL  = 2000;
	localparam int unsigned CALM_FROM   = 1750;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       token_valid = 1'b0;
	logic       token_ready;
	logic [7:0] token = 8'h00;
	logic       result_valid;
	logic       result_ready = 1'b0;
	status_t    status;
	logic [1:0] expansions;

	parse_scoreboard sb;
	bit              calm = 1'b0;
	int unsigned     gap_pct = 0;
	int unsigned     fed = 0;
	int unsigned     stall_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	ll1_expression_parser_unit #(
		.STACK_DEPTH(STACK_DEPTH_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token(token),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.expansions(expansions)
	);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_verdict(status, expansions);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((token_valid && token_ready) || (result_valid && result_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d results still due",
					STALL_LIMIT, sb.due.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				result_ready <= 1'b1;
				n = $urandom_range(1, 40);
			end else begin
				result_ready <= 1'b0;
				n = $urandom_range(1, 15);
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic feed(input logic [7:0] ch);
		if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			token_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		token <= ch;
		token_valid <= 1'b1;
		@(posedge clk);
		while (!token_ready)
			@(posedge clk);
		sb.note_token(ch);
		fed++;
	endtask

	task automatic feed_string(input string s);
		for (int k = 0; k < s.len(); k++)
			feed(s[k]);
	endtask

	// each open paren grows the stack by three, so past about twenty it overflows
	task automatic deep_nest(input int unsigned k);
		repeat (k) feed(CH_LP);
		feed(CH_ID);
		repeat (k) feed(CH_RP);
		feed(CH_END);
	endtask

	function automatic string expr_text(input int unsigned depth);
		string       s;
		int unsigned terms;
		int unsigned factors;
		s = "";
		terms = $urandom_range(1, 3);
		for (int a = 0; a < terms; a++) begin
			if (a != 0)
				s = {s, "+"};
			factors = $urandom_range(1, 3);
			for (int b = 0; b < factors; b++) begin
				if (b != 0)
					s = {s, "*"};
				if (depth > 0 && $urandom_range(0, 3) == 0)
					s = {s, "(", expr_text(depth - 1), ")"};
				else
					s = {s, "i"};
			end
		end
		return s;
	endfunction

	initial begin
		string       s;
		string       glyphs;
		int unsigned kind;
		int unsigned pos;
		sb = new();
		glyphs = "i+*()$";
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every terminal, three-rule token, both reject paths, discarding
		gap_pct = 0;
		feed_string("i$");
		feed_string("(i+i)*i$");
		feed_string("$");
		feed_string(")i$");
		feed(8'h00);
		feed(8'hff);
		feed(CH_END);
		gap_pct = 40;
		feed_string("ii$");
		feed_string("i+$");

		deep_nest(35);
		while (fed < TOKEN_GOAL) begin
			calm = (fed >= CALM_FROM);
			gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				feed_string({expr_text($urandom_range(0, 3)), "$"});
			end else if (kind < 80) begin
				s = {expr_text($urandom_range(0, 3)), "$"};
				pos = $urandom_range(0, s.len() - 1);
				if ($urandom_range(0, 1))
					s[pos] = glyphs[$urandom_range(0, 5)];
				else
					s[pos] = 8'($urandom_range(1, 255));
				feed_string(s);
			end else if (kind < 87) begin
				s = expr_text($urandom_range(0, 2));
				feed_string(s.substr(0, $urandom_range(0, s.len() - 1)));
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 8)) feed(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1))
					feed(CH_END);
			end else begin
				deep_nest($urandom_range(20, 40));
			end
		end
		token_valid <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d token words: %0d strings accepted, %0d rejected, %0d ignored, %0d overflows",
			sb.tokens, sb.accepts, sb.rejects, sb.ignored, sb.overflows);
		$display("%0d result words checked, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
design/ll1ep_pkg.sv
design/ll1ep_cell.sv
design/ll1_expression_parser_unit.sv
design/ll1ep_checker.sv
sim/parse_check_pkg.sv
sim/testbench.sv
